// File: sv/anbs_pkg.sv
`default_nettype none

package anbs_pkg;

    // Width of the in-frame byte position counter and of offset/length fields
    localparam int POS_BITS = 24;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam int KIND_BITS = 6;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_IDX_CODEC = 1'b0;

    // NAL unit type codes
    localparam logic [KIND_BITS-1:0] H264_IDR      = 6'd5;
    localparam logic [KIND_BITS-1:0] H264_SPS      = 6'd7;
    localparam logic [KIND_BITS-1:0] H264_PPS      = 6'd8;
    localparam logic [KIND_BITS-1:0] HEVC_IRAP_LO  = 6'd16;
    localparam logic [KIND_BITS-1:0] HEVC_IRAP_HI  = 6'd23;
    localparam logic [KIND_BITS-1:0] HEVC_VPS      = 6'd32;
    localparam logic [KIND_BITS-1:0] HEVC_SPS      = 6'd33;
    localparam logic [KIND_BITS-1:0] HEVC_PPS      = 6'd34;

    localparam logic [7:0] START_CODE_TAIL = 8'h01;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_frame;
        logic       keyframe_hint;
    } in_word_t;

    typedef struct packed {
        logic                 nal_valid;
        logic [POS_BITS-1:0]  nal_offset;
        logic [POS_BITS-1:0]  nal_length;
        logic [KIND_BITS-1:0] nal_kind;
        logic                 is_parameter_set;
        logic                 frame_end;
        logic                 frame_keyframe;
        logic                 no_nal_error;
        logic                 frame_overflow;
    } out_word_t;

    // Random-access point check for the selected codec
    function automatic logic kind_is_key(input logic hevc, input logic [KIND_BITS-1:0] k);
        if (hevc)
            return (k >= HEVC_IRAP_LO) && (k <= HEVC_IRAP_HI);
        else
            return k == H264_IDR;
    endfunction

    // Parameter-set check for the selected codec
    function automatic logic kind_is_ps(input logic hevc, input logic [KIND_BITS-1:0] k);
        if (hevc)
            return (k == HEVC_VPS) || (k == HEVC_SPS) || (k == HEVC_PPS);
        else
            return (k == H264_SPS) || (k == H264_PPS);
    endfunction

endpackage

`default_nettype wire

// File: sv/annex_b_nal_splitter_top.sv
`default_nettype none

// Annex-B NAL splitter. Feed one frame as a stream of byte words, the final
// byte flagged with last_of_frame. A byte is taken every cycle while the
// result register is free or being drained, so the sustained rate is one byte
// per cycle; the single parser state update per byte sets that figure. Each
// result word appears in the cycle after the byte that causes it: one word per
// completed non-empty NAL, and always one word with frame_end on the last
// byte (which may also carry the final NAL). Offsets and lengths are in bytes
// within the frame; lengths exclude trailing zero bytes. Register 0 at byte
// address 0 (bit 0, reset 1) selects HEVC rules, 0 selects H.264; write it
// only between frames.
module annex_b_nal_splitter_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire anbs_pkg::in_word_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output anbs_pkg::out_word_t                 out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [anbs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [anbs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [anbs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import anbs_pkg::*;

    logic      codec_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    logic      accept;
    logic      res_valid;
    out_word_t res_word;
    logic      reg_hit;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_IDX_CODEC);
    assign prdata  = reg_hit ? {{(APB_DATA_W-1){1'b0}}, codec_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            codec_reg <= 1'b1;
        else if (psel && penable && pwrite && pready && reg_hit)
            codec_reg <= pwdata[0];
    end

    // Take a byte whenever the result register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    anbs_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .in_word       (in_data),
        .codec_is_hevc (codec_reg),
        .res_valid     (res_valid),
        .res_word      (res_word)
    );

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= res_valid;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            out_word_reg <= res_word;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

`ifndef SYNTH
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last_of_frame |=> out_valid)
        else $error("last byte of frame produced no result word");

    a_plain_is_nal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.frame_end |-> out_data.nal_valid)
        else $error("result word carries neither NAL nor frame end");

    a_idle_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.nal_valid |-> out_data.nal_offset == '0
        && out_data.nal_length == '0 && out_data.nal_kind == '0
        && !out_data.is_parameter_set)
        else $error("NAL fields not cleared on frame-end-only word");

    a_nal_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.nal_valid |-> out_data.nal_length != '0)
        else $error("empty NAL reported");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire

// File: sv/anbs_core.sv
`default_nettype none

module anbs_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire anbs_pkg::in_word_t in_word,
    input  wire logic               codec_is_hevc,
    output logic                    res_valid,
    output anbs_pkg::out_word_t     res_word
);
    import anbs_pkg::*;

    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [1:0]           zero_run_reg, zero_run_next;
    logic                 synced_reg, synced_next;
    logic                 await_reg, await_next;
    logic [POS_BITS-1:0]  start_reg, start_next;
    logic [POS_BITS-1:0]  end_reg, end_next;
    logic [KIND_BITS-1:0] kind_reg, kind_next;
    logic                 key_seen_reg, key_seen_next;
    logic                 nal_seen_reg, nal_seen_next;
    logic                 ovf_reg, ovf_next;

    logic [7:0]           b;
    logic                 is_zero;
    logic                 start_code;
    logic                 emit;
    logic                 emit_key;
    logic [POS_BITS-1:0]  pos_inc;

    assign b          = in_word.data_byte;
    assign is_zero    = (b == 8'h00);
    assign start_code = (b == START_CODE_TAIL) && (zero_run_reg >= 2'd2);
    assign pos_inc    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    // Parse one byte: header capture, start code detection, NAL extent
    always_comb
    begin
        synced_next = synced_reg;
        await_next  = await_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        kind_next   = kind_reg;
        emit        = 1'b0;

        if (synced_reg && await_reg)
        begin
            kind_next  = codec_is_hevc ? b[6:1] : {1'b0, b[4:0]};
            start_next = pos_reg;
            end_next   = is_zero ? pos_reg : pos_inc;
            await_next = 1'b0;
        end
        else if (start_code)
        begin
            emit        = synced_reg && (end_reg > start_reg);
            synced_next = 1'b1;
            await_next  = 1'b1;
        end
        else if (synced_reg && !is_zero)
        begin
            end_next = pos_inc;
        end

        // Flush the open NAL on the last byte of the frame
        if (in_word.last_of_frame && !emit && synced_next && !await_next
            && (end_next > start_next))
            emit = 1'b1;
    end

    assign zero_run_next = !is_zero ? 2'd0 :
                           (zero_run_reg == 2'd3) ? zero_run_reg : zero_run_reg + 2'd1;

    assign emit_key      = emit && kind_is_key(codec_is_hevc, kind_next);
    assign key_seen_next = key_seen_reg || emit_key;
    assign nal_seen_next = nal_seen_reg || emit;
    assign ovf_next      = ovf_reg || (pos_reg == POS_MAX);
    assign pos_next      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    // Build the result word
    always_comb
    begin
        res_word                  = '0;
        res_valid                 = emit || in_word.last_of_frame;
        if (emit)
        begin
            res_word.nal_valid        = 1'b1;
            res_word.nal_offset       = start_next;
            res_word.nal_length       = end_next - start_next;
            res_word.nal_kind         = kind_next;
            res_word.is_parameter_set = kind_is_ps(codec_is_hevc, kind_next);
        end
        if (in_word.last_of_frame)
        begin
            res_word.frame_end      = 1'b1;
            res_word.frame_keyframe = in_word.keyframe_hint || key_seen_next;
            res_word.no_nal_error   = !nal_seen_next;
            res_word.frame_overflow = ovf_reg;
        end
    end

    // Advance parser state; clear everything after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            zero_run_reg <= '0;
            synced_reg   <= 1'b0;
            await_reg    <= 1'b0;
            start_reg    <= '0;
            end_reg      <= '0;
            kind_reg     <= '0;
            key_seen_reg <= 1'b0;
            nal_seen_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else if (step)
        begin
            if (in_word.last_of_frame)
            begin
                pos_reg      <= '0;
                zero_run_reg <= '0;
                synced_reg   <= 1'b0;
                await_reg    <= 1'b0;
                start_reg    <= '0;
                end_reg      <= '0;
                kind_reg     <= '0;
                key_seen_reg <= 1'b0;
                nal_seen_reg <= 1'b0;
                ovf_reg      <= 1'b0;
            end
            else
            begin
                pos_reg      <= pos_next;
                zero_run_reg <= zero_run_next;
                synced_reg   <= synced_next;
                await_reg    <= await_next;
                start_reg    <= start_next;
                end_reg      <= end_next;
                kind_reg     <= kind_next;
                key_seen_reg <= key_seen_next;
                nal_seen_reg <= nal_seen_next;
                ovf_reg      <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire
